### hdl/bcsf_pkg.sv
`default_nettype none
package bcsf_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN,
        ST_EMPTY_OUT,
        ST_EM_RD,
        ST_EM_LD
    } bcsf_state_t;

    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_BORDER_OFFSET = 3'd2,
        CFG_MIN_AREA      = 3'd3,
        CFG_MAX_AREA      = 3'd4,
        CFG_NEAR_DISTANCE = 3'd5
    } bcsf_cfg_idx_t;

    localparam logic CMD_BOX       = 1'b0;
    localparam logic CMD_FRAME_END = 1'b1;
    localparam logic KIND_VERDICT  = 1'b0;
    localparam logic KIND_BOX      = 1'b1;

    localparam int NUM_PAIRS = 8;

    // corner pairs checked for nearness: bit i set selects the far corner (x2 or y2)
    localparam logic [NUM_PAIRS-1:0] PAIR_NX = 8'b0101_0000;
    localparam logic [NUM_PAIRS-1:0] PAIR_NY = 8'b0011_0100;
    localparam logic [NUM_PAIRS-1:0] PAIR_SX = 8'b1010_0010;
    localparam logic [NUM_PAIRS-1:0] PAIR_SY = 8'b1101_1000;

    localparam logic [11:0] RST_IMAGE_WIDTH   = 12'd640;
    localparam logic [11:0] RST_IMAGE_HEIGHT  = 12'd480;
    localparam logic [7:0]  RST_BORDER_OFFSET = 8'd20;
    localparam logic [24:0] RST_MIN_AREA      = 25'd2000;
    localparam logic [24:0] RST_MAX_AREA      = 25'd100000;
    localparam logic [7:0]  RST_NEAR_DISTANCE = 8'd4;

endpackage
`default_nettype wire

### hdl/bcsf_ram.sv
`default_nettype none
module bcsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### hdl/box_candidate_suppression_filter.sv
`default_nettype none
// Candidate box filter for one frame. A candidate (s_tuser = 0) yields one verdict
// once every stored box has been compared when the store holds boxes and the area is in
// range, and with no scan when the store is empty or the area is out of range. Every
// stored box is read from the box RAM, one per cycle, and checked for near corners and
// overlap in a two-stage compare pipeline. A frame end (s_tuser = 1) emits the stored
// boxes top first, each read through the single RAM read port once the output register
// is free, then clears the store; an empty store yields one box record, box_valid clear.
// The store is a RAM ring with a base pointer: a reversal is a flag flip, not a copy.
module box_candidate_suppression_filter #(
    parameter int MAX_BOXES  = 32,
    parameter int COORD_BITS = 12
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // cfg
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [24:0] cfg_data,
    // input stream
    input  wire logic s_tvalid,
    output      logic s_tready,
    // box_x, box_y, box_width, box_height, area_doubled, zero pad
    input  wire logic [((4*COORD_BITS+26+7)/8)*8-1:0] s_tdata,
    // command
    input  wire logic s_tuser,
    // output stream
    output      logic m_tvalid,
    input  wire logic m_tready,
    // accepted, overflow, box_valid, out_x1, out_y1, out_x2, out_y2, zero pad
    output      logic [((4*COORD_BITS+5+7)/8)*8-1:0] m_tdata,
    // result_kind
    output      logic m_tuser,
    output      logic m_tlast
);
    import bcsf_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int AW     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int DEPTH  = 1 << AW;
    localparam int CNTW   = $clog2(MAX_BOXES + 1);
    localparam int EW     = 4 * C + 2;
    localparam int OUT_BITS = 4 * C + 5;
    localparam int OUT_DW = ((OUT_BITS + 7) / 8) * 8;
    localparam int SW     = ((C + 1 > 12) ? C + 1 : 12) + 2;

    // configuration
    logic [11:0] img_w_reg, img_h_reg;
    logic [7:0]  border_reg, near_reg;
    logic [24:0] min_area_reg, max_area_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg    <= RST_IMAGE_WIDTH;
            img_h_reg    <= RST_IMAGE_HEIGHT;
            border_reg   <= RST_BORDER_OFFSET;
            min_area_reg <= RST_MIN_AREA;
            max_area_reg <= RST_MAX_AREA;
            near_reg     <= RST_NEAR_DISTANCE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:   img_w_reg    <= cfg_data[11:0];
                CFG_IMAGE_HEIGHT:  img_h_reg    <= cfg_data[11:0];
                CFG_BORDER_OFFSET: border_reg   <= cfg_data[7:0];
                CFG_MIN_AREA:      min_area_reg <= cfg_data;
                CFG_MAX_AREA:      max_area_reg <= cfg_data;
                CFG_NEAR_DISTANCE: near_reg     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input unpacking
    logic [C-1:0]  in_x, in_y, in_w, in_h;
    logic [25:0]   in_area;
    logic [C:0]    in_x2, in_y2;
    logic          in_area_ok, in_border_ok;
    logic signed [SW-1:0] lo_s, rx_s, by_s;
    logic signed [SW-1:0] ix1_s, iy1_s, ix2_s, iy2_s;

    assign in_x    = s_tdata[C-1:0];
    assign in_y    = s_tdata[2*C-1:C];
    assign in_w    = s_tdata[3*C-1:2*C];
    assign in_h    = s_tdata[4*C-1:3*C];
    assign in_area = s_tdata[4*C+25:4*C];
    assign in_x2   = {1'b0, in_x} + {1'b0, in_w};
    assign in_y2   = {1'b0, in_y} + {1'b0, in_h};

    always_comb
    begin
        lo_s  = $signed({{(SW-8){1'b0}}, border_reg});
        rx_s  = $signed({{(SW-12){1'b0}}, img_w_reg}) - lo_s;
        by_s  = $signed({{(SW-12){1'b0}}, img_h_reg}) - lo_s;
        ix1_s = $signed({{(SW-C){1'b0}}, in_x});
        iy1_s = $signed({{(SW-C){1'b0}}, in_y});
        ix2_s = $signed({{(SW-C-1){1'b0}}, in_x2});
        iy2_s = $signed({{(SW-C-1){1'b0}}, in_y2});
        in_area_ok = (in_area < {max_area_reg, 1'b0}) && (in_area > {min_area_reg, 1'b0});
        in_border_ok = !(ix1_s >= rx_s || iy1_s >= by_s || ix2_s >= rx_s || iy2_s >= by_s ||
                         ix1_s <= lo_s || iy1_s <= lo_s || ix2_s <= lo_s || iy2_s <= lo_s);
    end

    // control and candidate state
    bcsf_state_t state_reg, state_next;
    logic [CNTW-1:0] count_reg, k_reg;
    logic [AW-1:0]   base_reg;
    logic            rev_reg;
    logic            area_ok_reg, border_ok_reg, conflict_reg;
    logic [C-1:0]    cx1_reg, cy1_reg;
    logic [C:0]      cx2_reg, cy2_reg;
    logic            v1_reg, v2_reg;

    logic out_valid_reg, out_free, in_xfer;
    logic out_load;
    logic out_kind_next, out_acc_next, out_ovf_next, out_bv_next, out_last_next;
    logic out_kind_reg, out_acc_reg, out_ovf_reg, out_bv_reg, out_last_reg;
    logic [C-1:0] out_x1_reg, out_y1_reg;
    logic [C:0]   out_x2_reg, out_y2_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    // RAM
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;
    logic [CNTW-1:0] em_idx;
    logic          rev_new, keep, push;

    bcsf_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_tuser == CMD_FRAME_END)
                        state_next = (count_reg == '0) ? ST_EMPTY_OUT : ST_EM_RD;
                    else if (in_area_ok && count_reg != '0)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_SCAN:
            begin
                if (k_reg == count_reg - 1'b1)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_EMPTY_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_EM_RD:
            begin
                if (!out_valid_reg)
                    state_next = ST_EM_LD;
            end
            ST_EM_LD:
            begin
                state_next = (k_reg == count_reg - 1'b1) ? ST_IDLE : ST_EM_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        rev_new = rev_reg ^ (area_ok_reg && count_reg != '0);
        keep    = area_ok_reg && border_ok_reg && !conflict_reg;
        push    = keep && (count_reg < CNTW'(MAX_BOXES));
        em_idx  = rev_reg ? k_reg : (count_reg - 1'b1 - k_reg);

        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = base_reg + count_reg[AW-1:0];
        mem_wdata = {cy2_reg, cx2_reg, cy1_reg, cx1_reg};
        out_load      = 1'b0;
        out_kind_next = KIND_VERDICT;
        out_acc_next  = 1'b0;
        out_ovf_next  = 1'b0;
        out_bv_next   = 1'b0;
        out_last_next = 1'b1;

        unique case (state_reg)
            ST_SCAN:
            begin
                mem_re    = 1'b1;
                mem_raddr = base_reg + k_reg[AW-1:0];
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    out_acc_next = push;
                    out_ovf_next = keep && !push;
                    mem_we       = push;
                    if (rev_new)
                        mem_waddr = base_reg - 1'b1;
                end
            end
            ST_EMPTY_OUT:
            begin
                out_load      = out_free;
                out_kind_next = KIND_BOX;
            end
            ST_EM_RD:
            begin
                mem_re    = !out_valid_reg;
                mem_raddr = base_reg + em_idx[AW-1:0];
            end
            ST_EM_LD:
            begin
                out_load      = 1'b1;
                out_kind_next = KIND_BOX;
                out_bv_next   = 1'b1;
                out_last_next = (k_reg == count_reg - 1'b1);
            end
            default: ;
        endcase
    end

    // compare pipeline: stage 1 differences and overlap, stage 2 squared distances
    logic [C-1:0] sx1, sy1;
    logic [C:0]   sx2, sy2;
    logic [NUM_PAIRS-1:0] small_d;
    logic [7:0] adx_d [NUM_PAIRS];
    logic [7:0] ady_d [NUM_PAIRS];
    logic       ovl_d;
    logic [NUM_PAIRS-1:0] small_reg;
    logic [7:0] adx_reg [NUM_PAIRS];
    logic [7:0] ady_reg [NUM_PAIRS];
    logic       ovl_reg;
    logic       near_hit;

    function automatic logic axis_ovl(input logic [C:0] a, input logic [C:0] a2,
                                      input logic [C:0] c, input logic [C:0] c2);
        return (c >= a && c2 <= a2) ||
               (c <= a && c2 >= a && c2 <= a2) ||
               (c <= a && a <= c2 && c <= a2 && a2 <= c2) ||
               (c >= a && c <= a2 && c2 >= a2);
    endfunction

    assign sx1 = mem_rdata[C-1:0];
    assign sy1 = mem_rdata[2*C-1:C];
    assign sx2 = mem_rdata[3*C:2*C];
    assign sy2 = mem_rdata[4*C+1:3*C+1];

    always_comb
    begin
        logic signed [SW-1:0] ax, ay, bx, bay, dx, dy;
        logic [SW-1:0] adx, ady, nd;
        nd = {{(SW-8){1'b0}}, near_reg};
        for (int i = 0; i < NUM_PAIRS; i++)
        begin
            ax  = PAIR_NX[i] ? $signed({{(SW-C-1){1'b0}}, cx2_reg})
                             : $signed({{(SW-C){1'b0}}, cx1_reg});
            ay  = PAIR_NY[i] ? $signed({{(SW-C-1){1'b0}}, cy2_reg})
                             : $signed({{(SW-C){1'b0}}, cy1_reg});
            bx  = PAIR_SX[i] ? $signed({{(SW-C-1){1'b0}}, sx2})
                             : $signed({{(SW-C){1'b0}}, sx1});
            bay = PAIR_SY[i] ? $signed({{(SW-C-1){1'b0}}, sy2})
                             : $signed({{(SW-C){1'b0}}, sy1});
            dx  = ax - bx;
            dy  = ay - bay;
            adx = dx[SW-1] ? SW'(-dx) : SW'(dx);
            ady = dy[SW-1] ? SW'(-dy) : SW'(dy);
            small_d[i] = (adx < nd) && (ady < nd);
            adx_d[i] = adx[7:0];
            ady_d[i] = ady[7:0];
        end
        ovl_d = axis_ovl({1'b0, cx1_reg}, cx2_reg, {1'b0, sx1}, sx2) &&
                axis_ovl({1'b0, cy1_reg}, cy2_reg, {1'b0, sy1}, sy2);
    end

    always_comb
    begin
        logic [16:0] dsq;
        logic [15:0] lim;
        lim = {8'd0, near_reg} * {8'd0, near_reg};
        near_hit = 1'b0;
        for (int i = 0; i < NUM_PAIRS; i++)
        begin
            dsq = {9'd0, adx_reg[i]} * {9'd0, adx_reg[i]} +
                  {9'd0, ady_reg[i]} * {9'd0, ady_reg[i]};
            if (small_reg[i] && dsq < {1'b0, lim})
                near_hit = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        small_reg <= small_d;
        adx_reg   <= adx_d;
        ady_reg   <= ady_d;
        ovl_reg   <= ovl_d;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            k_reg        <= '0;
            base_reg     <= '0;
            rev_reg      <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            conflict_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == ST_SCAN);
            v2_reg    <= v1_reg;
            if (v2_reg && (near_hit || ovl_reg))
                conflict_reg <= 1'b1;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    k_reg        <= '0;
                    conflict_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    k_reg <= k_reg + 1'b1;
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        rev_reg <= rev_new;
                        if (push)
                        begin
                            count_reg <= count_reg + 1'b1;
                            if (rev_new)
                                base_reg <= base_reg - 1'b1;
                        end
                    end
                end
                ST_EMPTY_OUT:
                begin
                    if (out_free)
                        rev_reg <= 1'b0;
                end
                ST_EM_LD:
                begin
                    if (k_reg == count_reg - 1'b1)
                    begin
                        count_reg <= '0;
                        rev_reg   <= 1'b0;
                    end
                    k_reg <= k_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cx1_reg       <= in_x;
            cy1_reg       <= in_y;
            cx2_reg       <= in_x2;
            cy2_reg       <= in_y2;
            area_ok_reg   <= in_area_ok;
            border_ok_reg <= in_border_ok;
        end
        if (out_load)
        begin
            out_kind_reg <= out_kind_next;
            out_acc_reg  <= out_acc_next;
            out_ovf_reg  <= out_ovf_next;
            out_bv_reg   <= out_bv_next;
            out_last_reg <= out_last_next;
            if (out_bv_next)
            begin
                out_x1_reg <= sx1;
                out_y1_reg <= sy1;
                out_x2_reg <= sx2;
                out_y2_reg <= sy2;
            end
            else
            begin
                out_x1_reg <= '0;
                out_y1_reg <= '0;
                out_x2_reg <= '0;
                out_y2_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_DW-OUT_BITS){1'b0}}, out_y2_reg, out_x2_reg, out_y1_reg,
                       out_x1_reg, out_bv_reg, out_ovf_reg, out_acc_reg};

endmodule
`default_nettype wire
